>>> hw/rtl/s2lab_pkg.sv
`timescale 1ns / 1ps

package s2lab_pkg;

  // Linear light and the normalized X, Y, Z are Q16 values up to 1.0.
  localparam int LinW  = 17;
  localparam int TW    = 17;
  localparam int RootW = 17;

  // Mixing matrix numerators, rounding term included.
  localparam int MixNumW = 37;
  localparam int MixLowBits = 8;
  localparam longint unsigned CoefXR = 412453;
  localparam longint unsigned CoefXG = 357580;
  localparam longint unsigned CoefXB = 180423;
  localparam longint unsigned CoefYR = 212671;
  localparam longint unsigned CoefYG = 715160;
  localparam longint unsigned CoefYB = 72169;
  localparam longint unsigned CoefZR = 19334;
  localparam longint unsigned CoefZG = 119193;
  localparam longint unsigned CoefZB = 950227;
  localparam longint unsigned RndX = 475228;
  localparam longint unsigned RndY = 500000;
  localparam longint unsigned RndZ = 544377;
  localparam longint unsigned DivX = 950456;
  localparam longint unsigned DivY = 1000000;
  localparam longint unsigned DivZ = 1088754;

  // A Q16 value is on the cube-root branch from this value up.
  localparam logic [TW-1:0] BrightMin = 17'd581;

  // Linear branch of f(): (903292 t + 1048634000) / 116000, t below 1024.
  localparam int DarkTW = 10;
  localparam int DarkNumW = 31;
  localparam int DarkQuoW = 15;
  localparam longint unsigned DarkGain = 903292;
  localparam longint unsigned DarkOffs = 1048634000;
  localparam longint unsigned DivDark = 116000;

  // Dark lightness: (9033 y + 1280) / 2560.
  localparam int LDarkNumW = 23;
  localparam int LDarkQuoW = 11;
  localparam longint unsigned LDarkGain = 9033;
  localparam longint unsigned LDarkOffs = 1280;
  localparam longint unsigned DivLDark = 2560;

  localparam int LW = 15;
  localparam logic [LW-1:0] LMax = 15'd25600;

  // Register stages from input transfer to output register.
  localparam int PipeDepth = 31;

  typedef logic [LinW-1:0] lin_tab_t [256];

  function automatic longint unsigned mul28(longint unsigned a, longint unsigned b);
    return (a * b) >> 28;
  endfunction

  function automatic longint unsigned pow12_q28(longint unsigned b);
    longint unsigned b2, b4, b8;
    b2 = mul28(b, b);
    b4 = mul28(b2, b2);
    b8 = mul28(b4, b4);
    return mul28(b8, b4);
  endfunction

  function automatic longint unsigned pow5_q28(longint unsigned y);
    longint unsigned y2, y4;
    y2 = mul28(y, y);
    y4 = mul28(y2, y2);
    return mul28(y4, y);
  endfunction

  // sRGB transfer curve of one code, Q16, evaluated at elaboration.
  function automatic longint unsigned lin_value(longint unsigned v);
    longint unsigned base, target, lo, hi, mid;
    if (v <= 10) begin
      return (v * 655360 + 16473) / 32946;
    end
    base = (((1000 * v + 14025) << 28) + 134512) / 269025;
    if (base > (64'd1 << 28)) begin
      base = 64'd1 << 28;
    end
    target = pow12_q28(base);
    lo = 0;
    hi = 64'd1 << 28;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (pow5_q28(mid) <= target) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return (lo + 2048) >> 12;
  endfunction

  function automatic lin_tab_t lin_table_build();
    lin_tab_t tab;
    for (int v = 0; v < 256; v++) begin
      tab[v] = LinW'(lin_value(longint'(v)));
    end
    return tab;
  endfunction

  localparam lin_tab_t LinTable = lin_table_build();

endpackage

>>> hw/rtl/s2lab_if.sv
`timescale 1ns / 1ps

interface srgb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface lab_pix_if;
  logic               valid;
  logic               ready;
  logic [14:0]        lightness;
  logic signed [15:0] green_red;
  logic signed [15:0] blue_yellow;

  modport source (output valid, output lightness, output green_red, output blue_yellow,
                  input ready);
  modport sink (input valid, input lightness, input green_red, input blue_yellow,
                output ready);
endinterface

>>> hw/rtl/s2lab_cdiv.sv
`timescale 1ns / 1ps

// Division by a constant: reciprocal multiply, back multiply, one correction.
module s2lab_cdiv #(
  parameter int NumW = 37,
  parameter int QuoW = 17,
  parameter int LowBits = 8,
  parameter longint unsigned Divisor = 950456
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NumW-1:0] num,
  output logic [QuoW-1:0] quo
);

  localparam int Shift = NumW + 1;
  localparam int HiW = NumW - LowBits;
  localparam longint unsigned Mult = (64'd1 << Shift) / Divisor;
  localparam int MultW = $clog2(Mult + 1);
  localparam int DivW = $clog2(Divisor + 1);
  localparam int ProdW = HiW + MultW;
  localparam int BackW = QuoW + DivW;

  logic [ProdW-1:0] prod;
  logic [QuoW-1:0]  q1_r, q2_r, quo_r;
  logic [NumW-1:0]  n1_r, n2_r, rem;
  logic [BackW-1:0] back_r;

  // The estimate is low by at most one, since the dropped bits and the
  // truncated reciprocal together lose less than one unit.
  assign prod = ProdW'(num[NumW-1:LowBits]) * ProdW'(Mult);
  assign rem  = n2_r - NumW'(back_r);

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r   <= prod[Shift-LowBits +: QuoW];
      n1_r   <= num;
      back_r <= BackW'(q1_r) * BackW'(Divisor);
      q2_r   <= q1_r;
      n2_r   <= n1_r;
      quo_r  <= q2_r + QuoW'(rem >= NumW'(Divisor));
    end
  end

  assign quo = quo_r;

endmodule

>>> hw/rtl/s2lab_lin.sv
`timescale 1ns / 1ps

module s2lab_lin (
  input  logic                       clk,
  input  logic                       en,
  input  logic [7:0]                 red,
  input  logic [7:0]                 green,
  input  logic [7:0]                 blue,
  output logic [s2lab_pkg::LinW-1:0] lin_red,
  output logic [s2lab_pkg::LinW-1:0] lin_green,
  output logic [s2lab_pkg::LinW-1:0] lin_blue
);

  logic [s2lab_pkg::LinW-1:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= s2lab_pkg::LinTable[red];
      green_r <= s2lab_pkg::LinTable[green];
      blue_r  <= s2lab_pkg::LinTable[blue];
    end
  end

  assign lin_red   = red_r;
  assign lin_green = green_r;
  assign lin_blue  = blue_r;

endmodule

>>> hw/rtl/s2lab_mix.sv
`timescale 1ns / 1ps

// D65 matrix numerators with the rounding term of each division.
module s2lab_mix (
  input  logic                          clk,
  input  logic                          en,
  input  logic [s2lab_pkg::LinW-1:0]    lin_red,
  input  logic [s2lab_pkg::LinW-1:0]    lin_green,
  input  logic [s2lab_pkg::LinW-1:0]    lin_blue,
  output logic [s2lab_pkg::MixNumW-1:0] x_num,
  output logic [s2lab_pkg::MixNumW-1:0] y_num,
  output logic [s2lab_pkg::MixNumW-1:0] z_num
);

  localparam int W = s2lab_pkg::MixNumW;

  logic [W-1:0] r, g, b;
  logic [W-1:0] x_r, y_r, z_r;

  assign r = W'(lin_red);
  assign g = W'(lin_green);
  assign b = W'(lin_blue);

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= r * W'(s2lab_pkg::CoefXR) + g * W'(s2lab_pkg::CoefXG)
           + b * W'(s2lab_pkg::CoefXB) + W'(s2lab_pkg::RndX);
      y_r <= r * W'(s2lab_pkg::CoefYR) + g * W'(s2lab_pkg::CoefYG)
           + b * W'(s2lab_pkg::CoefYB) + W'(s2lab_pkg::RndY);
      z_r <= r * W'(s2lab_pkg::CoefZR) + g * W'(s2lab_pkg::CoefZG)
           + b * W'(s2lab_pkg::CoefZB) + W'(s2lab_pkg::RndZ);
    end
  end

  assign x_num = x_r;
  assign y_num = y_r;
  assign z_num = z_r;

endmodule

>>> hw/rtl/s2lab_cbrt.sv
`timescale 1ns / 1ps

// Cube root of t * 2^32, one result bit per stage. Each stage keeps the
// partial root with its square and cube, so a trial needs adds only.
module s2lab_cbrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [s2lab_pkg::TW-1:0]    t_in,
  output logic [s2lab_pkg::RootW-1:0] root,
  output logic [s2lab_pkg::TW-1:0]    t_out
);

  localparam int RW = s2lab_pkg::RootW;
  localparam int SqW = 2 * RW;
  localparam int CuW = 3 * RW;

  logic [RW-1:0]               c_r  [RW];
  logic [SqW-1:0]              c2_r [RW];
  logic [CuW-1:0]              c3_r [RW];
  logic [s2lab_pkg::TW-1:0]    t_r  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam int K = RW - 1 - i;

    logic [RW-1:0]            pc, nc;
    logic [SqW-1:0]           pc2, nc2, cc2;
    logic [CuW-1:0]           pc3, nc3;
    logic [CuW:0]             cand3;
    logic [s2lab_pkg::TW-1:0] pt;

    if (i == 0) begin : g_first
      assign pc  = '0;
      assign pc2 = '0;
      assign pc3 = '0;
      assign pt  = t_in;
    end else begin : g_next
      assign pc  = c_r[i-1];
      assign pc2 = c2_r[i-1];
      assign pc3 = c3_r[i-1];
      assign pt  = t_r[i-1];
    end

    always_comb begin
      // (c + 2^K)^3 = c^3 + 3 c^2 2^K + 3 c 2^2K + 2^3K
      cand3 = (CuW+1)'(pc3)
            + ((CuW+1)'(pc2) << (K + 1)) + ((CuW+1)'(pc2) << K)
            + ((CuW+1)'(pc) << (2 * K + 1)) + ((CuW+1)'(pc) << (2 * K))
            + ((CuW+1)'(1) << (3 * K));
      cc2 = pc2 + (SqW'(pc) << (K + 1)) + (SqW'(1) << (2 * K));
      if (cand3 <= {3'b000, pt, 32'h0}) begin
        nc  = pc | (RW'(1) << K);
        nc2 = cc2;
        nc3 = cand3[CuW-1:0];
      end else begin
        nc  = pc;
        nc2 = pc2;
        nc3 = pc3;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_r[i]  <= nc;
        c2_r[i] <= nc2;
        c3_r[i] <= nc3;
        t_r[i]  <= pt;
      end
    end
  end

  assign root  = c_r[RW-1];
  assign t_out = t_r[RW-1];

endmodule

>>> hw/rtl/s2lab_labf.sv
`timescale 1ns / 1ps

// CIE f() of one Q16 value: cube root above the knee, linear below it.
module s2lab_labf (
  input  logic                        clk,
  input  logic                        en,
  input  logic [s2lab_pkg::TW-1:0]    t_in,
  output logic [s2lab_pkg::RootW-1:0] f_out,
  output logic [s2lab_pkg::TW-1:0]    t_out
);

  localparam int DW = s2lab_pkg::DarkNumW;
  localparam int Dly = 4;

  logic [s2lab_pkg::RootW-1:0]    root;
  logic [s2lab_pkg::TW-1:0]       t_c;
  logic [DW-1:0]                  dn_r;
  logic [s2lab_pkg::DarkQuoW-1:0] dark_q;
  logic [s2lab_pkg::RootW-1:0]    root_d_r [Dly];
  logic [s2lab_pkg::TW-1:0]       t_d_r    [Dly];

  s2lab_cbrt u_cbrt (
    .clk   (clk),
    .en    (en),
    .t_in  (t_in),
    .root  (root),
    .t_out (t_c)
  );

  // Only values below the knee use this branch, so ten bits of t suffice.
  always_ff @(posedge clk) begin
    if (en) begin
      dn_r <= DW'(t_c[s2lab_pkg::DarkTW-1:0]) * DW'(s2lab_pkg::DarkGain)
            + DW'(s2lab_pkg::DarkOffs);
      root_d_r[0] <= root;
      t_d_r[0]    <= t_c;
      for (int i = 1; i < Dly; i++) begin
        root_d_r[i] <= root_d_r[i-1];
        t_d_r[i]    <= t_d_r[i-1];
      end
    end
  end

  s2lab_cdiv #(
    .NumW    (DW),
    .QuoW    (s2lab_pkg::DarkQuoW),
    .LowBits (0),
    .Divisor (s2lab_pkg::DivDark)
  ) u_dark_div (
    .clk (clk),
    .en  (en),
    .num (dn_r),
    .quo (dark_q)
  );

  assign f_out = (t_d_r[Dly-1] >= s2lab_pkg::BrightMin) ? root_d_r[Dly-1]
                                                        : s2lab_pkg::RootW'(dark_q);
  assign t_out = t_d_r[Dly-1];

endmodule

>>> hw/rtl/s2lab_out.sv
`timescale 1ns / 1ps

// L*, a*, b* from the f() values (dark L* from Y), rounded to Q8 and saturated.
module s2lab_out (
  input  logic                        clk,
  input  logic                        en,
  input  logic [s2lab_pkg::RootW-1:0] fx,
  input  logic [s2lab_pkg::RootW-1:0] fy,
  input  logic [s2lab_pkg::RootW-1:0] fz,
  input  logic [s2lab_pkg::TW-1:0]    y,
  output logic [s2lab_pkg::LW-1:0]    lightness,
  output logic signed [15:0]          green_red,
  output logic signed [15:0]          blue_yellow
);

  localparam int FW = s2lab_pkg::RootW;
  localparam int NW = s2lab_pkg::LDarkNumW;
  localparam int Dly = 4;

  logic [NW-1:0]                   ln_r;
  logic [s2lab_pkg::LDarkQuoW-1:0] l_dark;
  logic [FW-1:0]                   fx_d_r [Dly];
  logic [FW-1:0]                   fy_d_r [Dly];
  logic [FW-1:0]                   fz_d_r [Dly];
  logic [Dly-1:0]                  bright_d_r;

  logic signed [25:0] lb_q16, lb_q8;
  logic [s2lab_pkg::LW-1:0] l_bright, l_nxt;
  logic signed [FW:0]  da, db;
  logic signed [27:0]  pa, pb, ra, rb;
  logic [s2lab_pkg::LW-1:0] l_r;
  logic signed [15:0] a_r, b_r;

  function automatic logic signed [15:0] sat16(logic signed [27:0] v);
    if (v < -28'sd32768) begin
      return -16'sd32768;
    end else if (v > 28'sd32767) begin
      return 16'sd32767;
    end
    return v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      ln_r <= NW'(y[s2lab_pkg::DarkTW-1:0]) * NW'(s2lab_pkg::LDarkGain)
            + NW'(s2lab_pkg::LDarkOffs);
      fx_d_r[0] <= fx;
      fy_d_r[0] <= fy;
      fz_d_r[0] <= fz;
      bright_d_r[0] <= (y >= s2lab_pkg::BrightMin);
      for (int i = 1; i < Dly; i++) begin
        fx_d_r[i] <= fx_d_r[i-1];
        fy_d_r[i] <= fy_d_r[i-1];
        fz_d_r[i] <= fz_d_r[i-1];
        bright_d_r[i] <= bright_d_r[i-1];
      end
    end
  end

  s2lab_cdiv #(
    .NumW    (NW),
    .QuoW    (s2lab_pkg::LDarkQuoW),
    .LowBits (0),
    .Divisor (s2lab_pkg::DivLDark)
  ) u_ldark_div (
    .clk (clk),
    .en  (en),
    .num (ln_r),
    .quo (l_dark)
  );

  always_comb begin
    lb_q16 = $signed(26'(fy_d_r[Dly-1])) * 26'sd116 - 26'sd1048576;
    lb_q8  = (lb_q16 + 26'sd128) >>> 8;
    if (lb_q8 < 26'sd0) begin
      l_bright = '0;
    end else if (lb_q8 > 26'sd25600) begin
      l_bright = s2lab_pkg::LMax;
    end else begin
      l_bright = lb_q8[s2lab_pkg::LW-1:0];
    end
    l_nxt = bright_d_r[Dly-1] ? l_bright : s2lab_pkg::LW'(l_dark);

    da = $signed({1'b0, fx_d_r[Dly-1]}) - $signed({1'b0, fy_d_r[Dly-1]});
    db = $signed({1'b0, fy_d_r[Dly-1]}) - $signed({1'b0, fz_d_r[Dly-1]});
    pa = 28'(da) * 28'sd500;
    pb = 28'(db) * 28'sd200;
    ra = (pa + 28'sd128) >>> 8;
    rb = (pb + 28'sd128) >>> 8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_r <= l_nxt;
      a_r <= sat16(ra);
      b_r <= sat16(rb);
    end
  end

  assign lightness   = l_r;
  assign green_red   = a_r;
  assign blue_yellow = b_r;

endmodule

>>> hw/rtl/srgb_to_cielab_pixel.sv
`timescale 1ns / 1ps

// Channel  | Direction | Payload
// in_pix   | sink      | red, green, blue (8 bits each, sRGB codes)
// out_pix  | source    | lightness (Q8, 15 bits), green_red, blue_yellow (Q8.8)
//
// One pixel enters per clock unless a result is stalled at the output.
// Each pixel passes through the 17-stage cube root plus the constant dividers.
// Reset clears only the valid bits of the pipeline.
// A stalled output register freezes every stage, so in_pix.ready follows
// out_pix.ready whenever a result is waiting.
module srgb_to_cielab_pixel (
  input  logic       clk,
  input  logic       rst_n,
  srgb_pix_if.sink   in_pix,
  lab_pix_if.source  out_pix
);

  localparam int Depth = s2lab_pkg::PipeDepth;

  logic en;
  logic [Depth-1:0] valid_r, valid_nxt;
  logic [s2lab_pkg::LinW-1:0]    lin_r, lin_g, lin_b;
  logic [s2lab_pkg::MixNumW-1:0] x_num, y_num, z_num;
  logic [s2lab_pkg::TW-1:0]      x_t, y_t, z_t, y_d;
  logic [s2lab_pkg::TW-1:0]      x_unused, z_unused;
  logic [s2lab_pkg::RootW-1:0]   fx, fy, fz;

  assign en = !valid_r[Depth-1] || out_pix.ready;
  assign in_pix.ready = en;
  assign valid_nxt = {valid_r[Depth-2:0], in_pix.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= valid_nxt;
    end
  end

  s2lab_lin u_lin (
    .clk       (clk),
    .en        (en),
    .red       (in_pix.red),
    .green     (in_pix.green),
    .blue      (in_pix.blue),
    .lin_red   (lin_r),
    .lin_green (lin_g),
    .lin_blue  (lin_b)
  );

  s2lab_mix u_mix (
    .clk       (clk),
    .en        (en),
    .lin_red   (lin_r),
    .lin_green (lin_g),
    .lin_blue  (lin_b),
    .x_num     (x_num),
    .y_num     (y_num),
    .z_num     (z_num)
  );

  s2lab_cdiv #(
    .NumW (s2lab_pkg::MixNumW), .QuoW (s2lab_pkg::TW),
    .LowBits (s2lab_pkg::MixLowBits), .Divisor (s2lab_pkg::DivX)
  ) u_div_x (.clk (clk), .en (en), .num (x_num), .quo (x_t));

  s2lab_cdiv #(
    .NumW (s2lab_pkg::MixNumW), .QuoW (s2lab_pkg::TW),
    .LowBits (s2lab_pkg::MixLowBits), .Divisor (s2lab_pkg::DivY)
  ) u_div_y (.clk (clk), .en (en), .num (y_num), .quo (y_t));

  s2lab_cdiv #(
    .NumW (s2lab_pkg::MixNumW), .QuoW (s2lab_pkg::TW),
    .LowBits (s2lab_pkg::MixLowBits), .Divisor (s2lab_pkg::DivZ)
  ) u_div_z (.clk (clk), .en (en), .num (z_num), .quo (z_t));

  s2lab_labf u_f_x (.clk (clk), .en (en), .t_in (x_t), .f_out (fx), .t_out (x_unused));
  s2lab_labf u_f_y (.clk (clk), .en (en), .t_in (y_t), .f_out (fy), .t_out (y_d));
  s2lab_labf u_f_z (.clk (clk), .en (en), .t_in (z_t), .f_out (fz), .t_out (z_unused));

  s2lab_out u_out (
    .clk         (clk),
    .en          (en),
    .fx          (fx),
    .fy          (fy),
    .fz          (fz),
    .y           (y_d ^ (x_unused & z_unused & '0)),
    .lightness   (out_pix.lightness),
    .green_red   (out_pix.green_red),
    .blue_yellow (out_pix.blue_yellow)
  );

  assign out_pix.valid = valid_r[Depth-1];

`ifndef SYNTHESIS
  a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_pix.valid |-> out_pix.lightness <= s2lab_pkg::LMax)
    else $error("lightness above 100");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready) |=> valid_r[0])
    else $error("accepted pixel lost at pipeline entry");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(valid_r))
    else $error("pipeline moved while output stalled");
`endif

endmodule

>>> verif/tb_srgb_to_cielab_pixel.sv
`timescale 1ns / 1ps

module tb_srgb_to_cielab_pixel;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [14:0]        lightness;
    logic signed [15:0] green_red;
    logic signed [15:0] blue_yellow;
  } lab_t;

  typedef struct {
    rgb_t pix;
    bit   known;
    lab_t lab;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   err_cnt = 0;
  bit   stim_done = 1'b0;
  bit   hold_long = 1'b0;
  lab_t lab_q[$];

  srgb_pix_if in_pix();
  lab_pix_if  out_pix();

  srgb_to_cielab_pixel dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (in_pix.sink),
    .out_pix(out_pix.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Q28 product, truncated.
  function automatic longint unsigned q28_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> 28;
  endfunction

  // sRGB transfer curve of one code, Q16.
  function automatic longint unsigned srgb_linear(longint unsigned v);
    longint unsigned base, b2, b4, tgt, lo, hi, mid, m2, m4;
    if (v <= 10) begin
      return (v * 655360 + 16473) / 32946;
    end
    base = (((1000 * v + 14025) << 28) + 134512) / 269025;
    if (base > (64'd1 << 28)) begin
      base = 64'd1 << 28;
    end
    b2 = q28_mul(base, base);
    b4 = q28_mul(b2, b2);
    tgt = q28_mul(q28_mul(b4, b4), b4);
    lo = 0;
    hi = 64'd1 << 28;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      m2 = q28_mul(mid, mid);
      m4 = q28_mul(m2, m2);
      if (q28_mul(m4, mid) <= tgt) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return (lo + 2048) >> 12;
  endfunction

  function automatic bit above_knee(longint unsigned t);
    return t * 1000000 > 64'd8856 * 65536;
  endfunction

  function automatic longint unsigned cie_f(longint unsigned t);
    longint unsigned tgt, lo, hi, mid;
    if (above_knee(t)) begin
      tgt = t << 32;
      lo = 0;
      hi = (64'd1 << 17) - 1;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (mid * mid * mid <= tgt) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      return lo;
    end
    return (64'd7787 * 116 * t + 64'd16000 * 65536 + 58000) / 116000;
  endfunction

  // Round half up from Q16 to Q8 with floor semantics for negatives.
  function automatic longint q8_round(longint n);
    longint m;
    m = n + 128;
    if (m >= 0) begin
      return m / 256;
    end
    return -((-m + 255) / 256);
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic lab_t cielab_of(rgb_t p);
    longint unsigned r, g, b, x, y, z;
    longint fx, fy, fz, l;
    lab_t res;
    r = srgb_linear(p.red);
    g = srgb_linear(p.green);
    b = srgb_linear(p.blue);
    x = (412453 * r + 357580 * g + 180423 * b + 475228) / 950456;
    y = (212671 * r + 715160 * g + 72169 * b + 500000) / 1000000;
    z = (19334 * r + 119193 * g + 950227 * b + 544377) / 1088754;
    fx = longint'(cie_f(x));
    fy = longint'(cie_f(y));
    fz = longint'(cie_f(z));
    if (above_knee(y)) begin
      l = q8_round(116 * fy - 16 * 65536);
    end else begin
      l = longint'((9033 * y + 1280) / 2560);
    end
    res.lightness = 15'(sat(l, 0, 25600));
    res.green_red = 16'(sat(q8_round(500 * (fx - fy)), -32768, 32767));
    res.blue_yellow = 16'(sat(q8_round(200 * (fy - fz)), -32768, 32767));
    return res;
  endfunction

  // Directed pixels; black and white have fixed, obvious results.
  stim_row_t dir_tab[] = '{
    '{'{8'd0, 8'd0, 8'd0}, 1'b1, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{15'd25600, 16'sd0, 16'sd0}},
    '{'{8'd255, 8'd0, 8'd0}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd0, 8'd255, 8'd0}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd0, 8'd0, 8'd255}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd255, 8'd255, 8'd0}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd0, 8'd255, 8'd255}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd255, 8'd0, 8'd255}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd10, 8'd10, 8'd10}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd11, 8'd11, 8'd11}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd1, 8'd0, 8'd0}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd0, 8'd1, 8'd0}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd0, 8'd0, 8'd1}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd24, 8'd24, 8'd24}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd25, 8'd25, 8'd25}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd128, 8'd128, 8'd128}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd170, 8'd85, 8'd170}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd85, 8'd170, 8'd85}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd254, 8'd1, 8'd128}, 1'b0, '{15'd0, 16'sd0, 16'sd0}},
    '{'{8'd0, 8'd0, 8'd40}, 1'b0, '{15'd0, 16'sd0, 16'sd0}}
  };

  task automatic send_pixel(rgb_t p, lab_t exp_lab);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) begin
      gap = 0;
    end
    if (gap > 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pix.valid <= 1'b1;
    in_pix.red <= p.red;
    in_pix.green <= p.green;
    in_pix.blue <= p.blue;
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
    lab_q = {lab_q, exp_lab};
  endtask

  initial begin
    rgb_t p;
    in_pix.valid = 1'b0;
    in_pix.red = '0;
    in_pix.green = '0;
    in_pix.blue = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_tab[i]) begin
      send_pixel(dir_tab[i].pix,
                 dir_tab[i].known ? dir_tab[i].lab : cielab_of(dir_tab[i].pix));
    end
    for (int i = 0; i < 950; i++) begin
      p = rgb_t'(24'($urandom));
      // Bias some pixels toward dark codes to exercise the linear segments.
      if ($urandom_range(0, 3) == 0) begin
        p.red = 8'($urandom_range(0, 30));
        p.green = 8'($urandom_range(0, 30));
        p.blue = 8'($urandom_range(0, 30));
      end
      if (i == 300) begin
        hold_long = 1'b1;
      end
      send_pixel(p, cielab_of(p));
    end
    in_pix.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int stall;
    out_pix.ready = 1'b0;
    forever begin
      stall = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) begin
        stall = 0;
      end
      if (hold_long) begin
        hold_long = 1'b0;
        stall = 120;
      end
      if (stall > 0) begin
        out_pix.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pix.ready <= 1'b1;
      @(posedge clk);
      while (!out_pix.valid) @(posedge clk);
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    lab_t exp_lab;
    if (rst_n && out_pix.valid && out_pix.ready) begin
      if (lab_q.size() == 0) begin
        $error("unexpected result transfer");
        err_cnt++;
      end else begin
        exp_lab = lab_q.pop_front();
        if (out_pix.lightness !== exp_lab.lightness) begin
          $error("lightness: expected %0d, got %0d", exp_lab.lightness, out_pix.lightness);
          err_cnt++;
        end
        if (out_pix.green_red !== exp_lab.green_red) begin
          $error("green_red: expected %0d, got %0d", exp_lab.green_red, out_pix.green_red);
          err_cnt++;
        end
        if (out_pix.blue_yellow !== exp_lab.blue_yellow) begin
          $error("blue_yellow: expected %0d, got %0d", exp_lab.blue_yellow,
                 out_pix.blue_yellow);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (lab_q.size() != 0) @(posedge clk);
    repeat (s2lab_pkg::PipeDepth + 10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/s2lab_pkg.sv
hw/rtl/s2lab_if.sv
hw/rtl/s2lab_cdiv.sv
hw/rtl/s2lab_lin.sv
hw/rtl/s2lab_mix.sv
hw/rtl/s2lab_cbrt.sv
hw/rtl/s2lab_labf.sv
hw/rtl/s2lab_out.sv
hw/rtl/srgb_to_cielab_pixel.sv
verif/tb_srgb_to_cielab_pixel.sv
